[hw/rtl/jddm_pkg.sv]
// Shared constants, types and the wheel leg function of the joystick drive mixer.
package jddm_pkg;

    localparam int AXIS_W = 10;
    localparam int SPEED_W = 9;
    localparam int SUM_W = 10;
    localparam int DUTY_W = 8;
    localparam int SCALED_W = 17;
    localparam int RECIP_W = 18;
    localparam int PROD_W = SCALED_W + RECIP_W;
    localparam int RECIP_SHIFT = 26;

    localparam logic [AXIS_W-1:0] DEAD_LOW = 10'd470;
    localparam logic [AXIS_W-1:0] DEAD_HIGH = 10'd550;
    localparam logic [DUTY_W-1:0] SPEED_MAX = 8'd255;

    // Reciprocals of 470 and 473 scaled by 2**26; exact for every product below 2**17.
    localparam logic [RECIP_W-1:0] RECIP_LOW = 18'd142785;
    localparam logic [RECIP_W-1:0] RECIP_HIGH = 18'd141880;

    localparam logic FOUR_WHEEL_RESET = 1'b1;

    typedef struct packed {
        logic [DUTY_W-1:0] a;
        logic [DUTY_W-1:0] b;
    } legs_t;

    function automatic legs_t wheel_legs(input logic signed [SUM_W-1:0] speed,
                                         input logic mirrored);
        logic forward;
        logic [SUM_W-1:0] mag;
        logic [DUTY_W-1:0] mag_clamped;
        logic [DUTY_W-1:0] duty;
        legs_t legs;
        forward = (speed > 0);
        mag = forward ? speed : -speed;
        mag_clamped = (mag > {2'b00, SPEED_MAX}) ? SPEED_MAX : mag[DUTY_W-1:0];
        duty = SPEED_MAX - mag_clamped;
        if (forward != mirrored)
        begin
            legs.a = SPEED_MAX;
            legs.b = duty;
        end
        else
        begin
            legs.a = duty;
            legs.b = SPEED_MAX;
        end
        return legs;
    endfunction

endpackage

[hw/rtl/jddm_axis_scale.sv]
// Two-stage dead band and linear scaling of one joystick axis to a signed speed.
module jddm_axis_scale
    import jddm_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [AXIS_W-1:0]         axis,
    output logic signed [SPEED_W-1:0] speed
);

    logic [SCALED_W-1:0] scaled_reg;
    logic [SCALED_W-1:0] scaled_next;
    logic                neg_reg;
    logic                neg_next;
    logic                high_reg;
    logic                high_next;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [SPEED_W-1:0] speed_next;
    logic [AXIS_W-1:0]   offset;
    logic [PROD_W-1:0]   prod;
    logic [DUTY_W-1:0]   quot;

    always_comb
    begin
        neg_next = (axis < DEAD_LOW);
        high_next = (axis > DEAD_HIGH);
        if (neg_next)
        begin
            offset = DEAD_LOW - axis;
        end
        else if (high_next)
        begin
            offset = axis - DEAD_HIGH;
        end
        else
        begin
            offset = '0;
        end
        scaled_next = {offset[SPEED_W-1:0], 8'd0} - {8'd0, offset[SPEED_W-1:0]};
    end

    always_comb
    begin
        prod = PROD_W'(scaled_reg) * PROD_W'(high_reg ? RECIP_HIGH : RECIP_LOW);
        quot = prod[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
        speed_next = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scaled_reg <= scaled_next;
            neg_reg <= neg_next;
            high_reg <= high_next;
            speed_reg <= speed_next;
        end
    end

    assign speed = speed_reg;

endmodule

[hw/rtl/joystick_differential_drive_mixer_unit.sv]
// Top level of the joystick differential drive mixer with its stream channels.
//
// Each input transaction carries one joystick sample: x_axis (steering) in
// s_axis_tdata[9:0] and y_axis (throttle) in s_axis_tdata[19:10]. Each output
// transaction carries the eight H-bridge leg duties, eight bits each.
// The datapath has three register stages: axis offset and scale by 255, the
// reciprocal multiply that divides by the span of each half axis, and the
// wheel mix with clamp and leg selection into the output register. One sample
// can be accepted every cycle while the pipeline is not stalled.
// All stages advance together; when the receiver holds m_axis_tready low
// with a result pending, the whole pipeline and s_axis_tready stall, so
// nothing is lost or repeated.
// The cfg channel writes four_wheel and is always ready. When it is zero the
// rear duties repeat their held values. Reset sets four_wheel to one, all held
// rear duties to 255 and empties the pipeline.
module joystick_differential_drive_mixer_unit
    import jddm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x_axis[9:0], y_axis[19:10], zero pad [23:20]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // front_left_a, front_left_b, front_right_a, front_right_b,
    // rear_left_a, rear_left_b, rear_right_a, rear_right_b, 8 bits each
    output logic [63:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic en;
    logic [2:0] valid_reg;
    logic [2:0] valid_next;
    logic four_wheel_reg;
    logic four_wheel_next;
    logic signed [SPEED_W-1:0] steer;
    logic signed [SPEED_W-1:0] throttle;
    logic signed [SUM_W-1:0] left_sum;
    logic signed [SUM_W-1:0] right_sum;
    legs_t left_legs;
    legs_t right_legs;
    legs_t rear_left_reg;
    legs_t rear_left_next;
    legs_t rear_right_reg;
    legs_t rear_right_next;
    logic [63:0] data_reg;
    logic [63:0] data_next;

    assign en = !valid_reg[2] || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready = 1'b1;

    jddm_axis_scale u_steer (
        .clk   (clk),
        .en    (en),
        .axis  (s_axis_tdata[AXIS_W-1:0]),
        .speed (steer)
    );

    jddm_axis_scale u_throttle (
        .clk   (clk),
        .en    (en),
        .axis  (s_axis_tdata[2*AXIS_W-1:AXIS_W]),
        .speed (throttle)
    );

    always_comb
    begin
        left_sum = SUM_W'(throttle) + SUM_W'(steer);
        right_sum = SUM_W'(throttle) - SUM_W'(steer);
        left_legs = wheel_legs(left_sum, 1'b0);
        right_legs = wheel_legs(right_sum, 1'b1);
        rear_left_next = rear_left_reg;
        rear_right_next = rear_right_reg;
        if (en && valid_reg[1] && four_wheel_reg)
        begin
            rear_left_next = left_legs;
            rear_right_next = right_legs;
        end
        data_next = {rear_right_next.b, rear_right_next.a,
                     rear_left_next.b, rear_left_next.a,
                     right_legs.b, right_legs.a, left_legs.b, left_legs.a};
        valid_next = en ? {valid_reg[1:0], s_axis_tvalid} : valid_reg;
        four_wheel_next = cfg_valid ? cfg_data : four_wheel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            four_wheel_reg <= FOUR_WHEEL_RESET;
            rear_left_reg <= '{a: SPEED_MAX, b: SPEED_MAX};
            rear_right_reg <= '{a: SPEED_MAX, b: SPEED_MAX};
        end
        else
        begin
            valid_reg <= valid_next;
            four_wheel_reg <= four_wheel_next;
            rear_left_reg <= rear_left_next;
            rear_right_reg <= rear_right_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign m_axis_tvalid = valid_reg[2];
    assign m_axis_tdata = data_reg;

endmodule
